// ===== design/rk4_pkg.sv =====
// ---------------------------------------------------------------------------
// rk4_pkg
// Shared types, constants and arithmetic helpers for the RK4 cosine stepper.
// ---------------------------------------------------------------------------
package rk4_pkg;

   localparam int FRAC_BITS  = 20;
   localparam int WORD_BITS  = 32;
   localparam int SLOPE_BITS = FRAC_BITS + 2;
   localparam int CNT_BITS   = 16;
   localparam int MUL_BITS   = 34;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int RND_SHIFT  = 30 - FRAC_BITS;

   typedef logic signed [WORD_BITS-1:0]  word_type;
   typedef logic signed [SLOPE_BITS-1:0] slope_type;
   typedef logic signed [MUL_BITS-1:0]   mul_op_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      mul_op_type op_a;
      mul_op_type op_b;
   } mul_req_type;

   typedef struct packed {
      logic     start;
      word_type x_arg;
      word_type y_arg;
   } slp_req_type;

   typedef struct packed {
      logic      done;
      slope_type slope;
   } slp_rsp_type;

   typedef struct packed {
      logic     sat;
      word_type val;
   } sat_word_type;

   typedef struct packed {
      logic [32:0] mult;
      logic [5:0]  shift;
   } recip_type;

   // register indexes
   localparam logic [1:0] CSR_START_X    = 2'd0;
   localparam logic [1:0] CSR_START_Y    = 2'd1;
   localparam logic [1:0] CSR_STEP_SIZE  = 2'd2;
   localparam logic [1:0] CSR_NUM_POINTS = 2'd3;

   localparam word_type            START_X_RST    = '0;
   localparam word_type            START_Y_RST    = '0;
   localparam word_type            STEP_SIZE_RST  = 32'sd104858;
   localparam logic [CNT_BITS-1:0] NUM_POINTS_RST = 16'd20;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // 1 / (2 pi) in Q64, split into two halves
   localparam logic [31:0] INV_2PI_LO  = 32'h9391054A;
   localparam logic [29:0] INV_2PI_HI  = 30'h28BE60DB;
   localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
   localparam logic signed [31:0] Q30_ONE = 32'sh40000000;

   // reciprocals m = ceil(2^s / d) for exact division of 32-bit values
   localparam logic [32:0] RCP_132 = 33'(((65'd1 << 40) + 65'd131) / 65'd132);
   localparam logic [32:0] RCP_90  = 33'(((65'd1 << 39) + 65'd89) / 65'd90);
   localparam logic [32:0] RCP_56  = 33'(((65'd1 << 38) + 65'd55) / 65'd56);
   localparam logic [32:0] RCP_30  = 33'(((65'd1 << 37) + 65'd29) / 65'd30);
   localparam logic [32:0] RCP_12  = 33'(((65'd1 << 36) + 65'd11) / 65'd12);
   localparam logic [32:0] RCP_2   = 33'(((65'd1 << 33) + 65'd1) / 65'd2);
   localparam logic [32:0] RCP_156 = 33'(((65'd1 << 40) + 65'd155) / 65'd156);
   localparam logic [32:0] RCP_110 = 33'(((65'd1 << 39) + 65'd109) / 65'd110);
   localparam logic [32:0] RCP_72  = 33'(((65'd1 << 39) + 65'd71) / 65'd72);
   localparam logic [32:0] RCP_42  = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
   localparam logic [32:0] RCP_20  = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
   localparam logic [32:0] RCP_6   = 33'(((65'd1 << 35) + 65'd5) / 65'd6);
   localparam logic [5:0]  SHIFT_6 = 6'd35;

   // bias that keeps the slope sum positive, a multiple of six
   localparam logic signed [SLOPE_BITS+3:0] AVG_BIAS =
      (SLOPE_BITS+4)'(6 << (FRAC_BITS + 1));
   localparam logic [SLOPE_BITS-1:0] AVG_UNBIAS = SLOPE_BITS'(1 << (FRAC_BITS + 1));
   localparam logic [SLOPE_BITS-1:0] SLOPE_ONE  = SLOPE_BITS'(1 << FRAC_BITS);

   function automatic recip_type div_recip(input logic sin_sel, input logic [2:0] step);
      recip_type r;
      unique case ({sin_sel, step})
         4'b0_000: r = '{RCP_132, 6'd40};
         4'b0_001: r = '{RCP_90,  6'd39};
         4'b0_010: r = '{RCP_56,  6'd38};
         4'b0_011: r = '{RCP_30,  6'd37};
         4'b0_100: r = '{RCP_12,  6'd36};
         4'b0_101: r = '{RCP_2,   6'd33};
         4'b1_000: r = '{RCP_156, 6'd40};
         4'b1_001: r = '{RCP_110, 6'd39};
         4'b1_010: r = '{RCP_72,  6'd39};
         4'b1_011: r = '{RCP_42,  6'd38};
         4'b1_100: r = '{RCP_20,  6'd37};
         4'b1_101: r = '{RCP_6,   SHIFT_6};
         default:  r = '{RCP_6,   SHIFT_6};
      endcase
      return r;
   endfunction

   function automatic sat_word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      sat_word_type r;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      r.sat = (s[WORD_BITS] != s[WORD_BITS-1]);
      r.val = r.sat ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
      return r;
   endfunction

   function automatic sat_word_type mul_sat(input prod_type p, input logic [5:0] sh);
      prod_type s;
      sat_word_type r;
      s = p >>> sh;
      r.sat = !((&s[PROD_BITS-1:WORD_BITS-1]) || !(|s[PROD_BITS-1:WORD_BITS-1]));
      r.val = r.sat ? (s[PROD_BITS-1] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
      return r;
   endfunction

endpackage

// ===== design/rk4_mul.sv =====
// ---------------------------------------------------------------------------
// rk4_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module rk4_mul import rk4_pkg::*; (
   input  logic        clock,
   input  mul_req_type mul_req,
   output prod_type    prod
);

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = PROD_BITS'(mul_req.op_a) * PROD_BITS'(mul_req.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== design/rk4_slope.sv =====
// ---------------------------------------------------------------------------
// rk4_slope
// Sequencer for one slope cos(x + y): phase reduction, quadrant and Taylor
// series, all through the shared multiplier.
// ---------------------------------------------------------------------------
module rk4_slope import rk4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  slp_req_type slp_req,
   input  prod_type    prod,
   output mul_req_type mul_req,
   output slp_rsp_type slp_rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_WB   = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   localparam logic [4:0] OP_XLO  = 5'd0;
   localparam logic [4:0] OP_XHI  = 5'd1;
   localparam logic [4:0] OP_YLO  = 5'd2;
   localparam logic [4:0] OP_YHI  = 5'd3;
   localparam logic [4:0] OP_ANG  = 5'd4;
   localparam logic [4:0] OP_SQR  = 5'd5;
   localparam logic [4:0] OP_SER  = 5'd6;
   localparam logic [4:0] OP_SERL = 5'd17;
   localparam logic [4:0] OP_SIN  = 5'd18;

   localparam logic signed [32:0] C_POS = 33'sd1073741824;
   localparam logic signed [32:0] C_NEG = -33'sd1073741824;

   logic [1:0]         state_ff, state_in;
   logic [4:0]         op_ff, op_in;
   word_type           xa_ff, xa_in, ya_ff, ya_in;
   logic signed [33:0] lo_ff, lo_in;
   logic [31:0]        phx_ff, phx_in, phase_ff, phase_in;
   logic [30:0]        ang_ff, ang_in;
   logic [31:0]        ang2_ff, ang2_in, num_ff, num_in;
   logic signed [31:0] t_ff, t_in;
   logic               done_ff, done_in;
   slope_type          slope_ff, slope_in;

   logic [4:0]         ser_off;
   logic [2:0]         ser_idx;
   logic               in_series;
   recip_type          rcp;
   logic [30:0]        t_pos;
   prod_type           hi_sum, quot;
   logic [31:0]        ph_part;
   logic signed [32:0] cn, cc;
   logic [32:0]        cu, cr;
   logic               neg;

   assign ser_off   = op_ff - OP_SER;
   assign ser_idx   = ser_off[3:1];
   assign in_series = (op_ff >= OP_SER) && (op_ff <= OP_SERL);
   assign rcp       = div_recip(phase_ff[30], ser_idx);
   assign t_pos     = t_ff[31] ? '0 : t_ff[30:0];
   assign hi_sum    = prod + PROD_BITS'(lo_ff);
   assign ph_part   = hi_sum[FRAC_BITS+31:FRAC_BITS];
   assign quot      = prod >> rcp.shift;

   // operand select
   always_comb begin
      mul_req = '0;
      if (op_ff == OP_XLO) begin
         mul_req.op_a = MUL_BITS'(xa_ff);
         mul_req.op_b = MUL_BITS'(INV_2PI_LO);
      end else if (op_ff == OP_XHI) begin
         mul_req.op_a = MUL_BITS'(xa_ff);
         mul_req.op_b = MUL_BITS'(INV_2PI_HI);
      end else if (op_ff == OP_YLO) begin
         mul_req.op_a = MUL_BITS'(ya_ff);
         mul_req.op_b = MUL_BITS'(INV_2PI_LO);
      end else if (op_ff == OP_YHI) begin
         mul_req.op_a = MUL_BITS'(ya_ff);
         mul_req.op_b = MUL_BITS'(INV_2PI_HI);
      end else if (op_ff == OP_ANG) begin
         mul_req.op_a = MUL_BITS'(phase_ff[29:0]);
         mul_req.op_b = MUL_BITS'(HALF_PI_Q32);
      end else if (op_ff == OP_SQR) begin
         mul_req.op_a = MUL_BITS'(ang_ff);
         mul_req.op_b = MUL_BITS'(ang_ff);
      end else if (in_series && !op_ff[0]) begin
         mul_req.op_a = MUL_BITS'(ang2_ff);
         mul_req.op_b = MUL_BITS'(t_pos);
      end else if (in_series) begin
         mul_req.op_a = MUL_BITS'(num_ff);
         mul_req.op_b = MUL_BITS'(rcp.mult);
      end else begin
         mul_req.op_a = MUL_BITS'(ang_ff);
         mul_req.op_b = MUL_BITS'(t_pos);
      end
   end

   // final sign, clamp and rounding
   always_comb begin
      neg = (phase_ff[31:30] == 2'd1) || (phase_ff[31:30] == 2'd2);
      cn  = neg ? -{t_ff[31], t_ff} : {t_ff[31], t_ff};
      if (cn > C_POS) begin
         cc = C_POS;
      end else if (cn < C_NEG) begin
         cc = C_NEG;
      end else begin
         cc = cn;
      end
      cu = 33'(cc + C_POS);
      cr = (cu + 33'(1 << (RND_SHIFT - 1))) >> RND_SHIFT;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      xa_in    = xa_ff;
      ya_in    = ya_ff;
      lo_in    = lo_ff;
      phx_in   = phx_ff;
      phase_in = phase_ff;
      ang_in   = ang_ff;
      ang2_in  = ang2_ff;
      num_in   = num_ff;
      t_in     = t_ff;
      done_in  = 1'b0;
      slope_in = slope_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (slp_req.start) begin
               xa_in    = slp_req.x_arg;
               ya_in    = slp_req.y_arg;
               op_in    = OP_XLO;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_WB;
         end
         S_WB: begin
            if ((op_ff == OP_XLO) || (op_ff == OP_YLO)) begin
               lo_in = prod[65:32];
            end else if (op_ff == OP_XHI) begin
               phx_in = ph_part;
            end else if (op_ff == OP_YHI) begin
               phase_in = phx_ff + ph_part;
            end else if (op_ff == OP_ANG) begin
               ang_in = prod[62:32];
            end else if (op_ff == OP_SQR) begin
               ang2_in = prod[61:30];
               t_in    = Q30_ONE;
            end else if (in_series && !op_ff[0]) begin
               num_in = prod[61:30];
            end else if (in_series) begin
               t_in = Q30_ONE - signed'(quot[31:0]);
            end else begin
               t_in = {1'b0, prod[60:30]};
            end
            if (((op_ff == OP_SERL) && !phase_ff[30]) || (op_ff == OP_SIN)) begin
               state_in = S_FIN;
            end else begin
               op_in    = op_ff + 5'd1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            slope_in = slope_type'(cr[SLOPE_BITS-1:0] - SLOPE_ONE);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_XLO;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff    <= xa_in;
      ya_ff    <= ya_in;
      lo_ff    <= lo_in;
      phx_ff   <= phx_in;
      phase_ff <= phase_in;
      ang_ff   <= ang_in;
      ang2_ff  <= ang2_in;
      num_ff   <= num_in;
      t_ff     <= t_in;
      slope_ff <= slope_in;
   end

   assign slp_rsp.done  = done_ff;
   assign slp_rsp.slope = slope_ff;

endmodule

// ===== design/rk4_ode_stepper_cosine_core.sv =====
// ---------------------------------------------------------------------------
// rk4_ode_stepper_cosine_core
// Fourth-order Runge-Kutta stepper for dy/dx = cos(x + y) in Q12.20.
//
//   channel | direction | handshake          | beat
//   req     | in        | req_valid/req_stall | restart flag
//   rsp     | out       | rsp_valid/rsp_stall | point, four slopes, flags
//   csr     | in        | csr_write_en        | index and data
//
// a step runs through the one shared 34x34 multiplier from accept to result:
// each slope is 18 or 19 products
// the next beat is taken once the previous step has finished and its result
// sits in the output register
// synchronous reset loads the register defaults and the initial point
// a stalled output holds the finished step in the last state until it drains
// ---------------------------------------------------------------------------
module rk4_ode_stepper_cosine_core import rk4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_x_value,
   output logic signed [31:0]    rsp_y_value,
   output logic signed [21:0]    rsp_slope_one,
   output logic signed [21:0]    rsp_slope_two,
   output logic signed [21:0]    rsp_slope_three,
   output logic signed [21:0]    rsp_slope_four,
   output logic [15:0]           rsp_point_number,
   output logic                  rsp_last_point,
   output logic                  rsp_saturated,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SLOPE = 4'd1;
   localparam logic [3:0] ST_SWAIT = 4'd2;
   localparam logic [3:0] ST_MK    = 4'd3;
   localparam logic [3:0] ST_PK    = 4'd4;
   localparam logic [3:0] ST_MA    = 4'd5;
   localparam logic [3:0] ST_PA    = 4'd6;
   localparam logic [3:0] ST_MY    = 4'd7;
   localparam logic [3:0] ST_PY    = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          kn_ff, kn_in;
   word_type            start_x_ff, start_y_ff, step_ff;
   logic [CNT_BITS-1:0] npts_ff;
   word_type            cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                clip_ff, clip_in;
   logic                rsp_valid_ff, rsp_valid_in;

   slope_type           k_ff [4];
   slope_type           k_in [4];
   word_type            ya_ff, ya_in, ny_ff, ny_in;
   slope_type           avg_ff, avg_in;
   logic                nsat_ff, nsat_in;

   word_type            rsp_x_ff, rsp_y_ff;
   slope_type           rsp_k_ff [4];
   logic [CNT_BITS-1:0] rsp_idx_ff;
   logic                rsp_last_ff, rsp_sat_ff;

   slp_req_type         slp_req;
   slp_rsp_type         slp_rsp;
   mul_req_type         slp_mul, top_mul, mul_req;
   prod_type            prod;

   sat_word_type        xh_s, xf_s, ka_s, ysum_s, ym_s, yn_s;
   recip_type           rcp6;
   logic signed [SLOPE_BITS+3:0] ksum;
   prod_type            qa;
   logic                accept, load, pop, last;

   rk4_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   rk4_slope u_slope (
      .clock   (clock),
      .reset   (reset),
      .slp_req (slp_req),
      .prod    (prod),
      .mul_req (slp_mul),
      .slp_rsp (slp_rsp)
   );

   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid_ff && !rsp_stall;
   assign load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign last   = ({1'b0, idx_ff} + 17'd1) >= {1'b0, npts_ff};

   assign xh_s   = sat_add(cur_x_ff, step_ff >>> 1);
   assign xf_s   = sat_add(cur_x_ff, step_ff);
   assign ka_s   = mul_sat(prod, (kn_ff == 2'd2) ? 6'(FRAC_BITS) : 6'(FRAC_BITS + 1));
   assign ysum_s = sat_add(cur_y_ff, ka_s.val);
   assign ym_s   = mul_sat(prod, 6'(FRAC_BITS));
   assign yn_s   = sat_add(cur_y_ff, ym_s.val);
   assign rcp6   = div_recip(1'b1, 3'd5);
   assign qa     = prod >> rcp6.shift;
   assign ksum   = (SLOPE_BITS+4)'(k_ff[0]) + ((SLOPE_BITS+4)'(k_ff[1]) <<< 1)
                 + ((SLOPE_BITS+4)'(k_ff[2]) <<< 1) + (SLOPE_BITS+4)'(k_ff[3])
                 + (SLOPE_BITS+4)'(3) + AVG_BIAS;

   always_comb begin
      slp_req.start = (state_ff == ST_SLOPE);
      slp_req.x_arg = (kn_ff == 2'd0) ? cur_x_ff : ((kn_ff == 2'd3) ? xf_s.val : xh_s.val);
      slp_req.y_arg = (kn_ff == 2'd0) ? cur_y_ff : ya_ff;
   end

   always_comb begin
      top_mul = '0;
      if (state_ff == ST_MA) begin
         top_mul.op_a = MUL_BITS'(ksum);
         top_mul.op_b = MUL_BITS'(rcp6.mult);
      end else if (state_ff == ST_MY) begin
         top_mul.op_a = MUL_BITS'(step_ff);
         top_mul.op_b = MUL_BITS'(avg_ff);
      end else begin
         top_mul.op_a = MUL_BITS'(step_ff);
         top_mul.op_b = MUL_BITS'(k_ff[kn_ff]);
      end
   end

   assign mul_req = ((state_ff == ST_SLOPE) || (state_ff == ST_SWAIT)) ? slp_mul : top_mul;

   always_comb begin
      state_in = state_ff;
      kn_in    = kn_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      idx_in   = idx_ff;
      clip_in  = clip_ff;
      k_in     = k_ff;
      ya_in    = ya_ff;
      ny_in    = ny_ff;
      avg_in   = avg_ff;
      nsat_in  = nsat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  cur_x_in = start_x_ff;
                  cur_y_in = start_y_ff;
                  idx_in   = '0;
                  clip_in  = 1'b0;
               end
               kn_in    = 2'd0;
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            state_in = ST_SWAIT;
         end
         ST_SWAIT: begin
            if (slp_rsp.done) begin
               k_in[kn_ff] = slp_rsp.slope;
               state_in    = (kn_ff == 2'd3) ? ST_MA : ST_MK;
            end
         end
         ST_MK: begin
            state_in = ST_PK;
         end
         ST_PK: begin
            ya_in    = ysum_s.val;
            kn_in    = kn_ff + 2'd1;
            state_in = ST_SLOPE;
         end
         ST_MA: begin
            state_in = ST_PA;
         end
         ST_PA: begin
            avg_in   = slope_type'(qa[SLOPE_BITS-1:0] - AVG_UNBIAS);
            state_in = ST_MY;
         end
         ST_MY: begin
            state_in = ST_PY;
         end
         ST_PY: begin
            ny_in    = yn_s.val;
            nsat_in  = xf_s.sat | ym_s.sat | yn_s.sat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               if (last) begin
                  cur_x_in = start_x_ff;
                  cur_y_in = start_y_ff;
                  idx_in   = '0;
                  clip_in  = 1'b0;
               end else begin
                  cur_x_in = xf_s.val;
                  cur_y_in = ny_ff;
                  idx_in   = idx_ff + 16'd1;
                  clip_in  = nsat_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kn_ff        <= 2'd0;
         start_x_ff   <= START_X_RST;
         start_y_ff   <= START_Y_RST;
         step_ff      <= STEP_SIZE_RST;
         npts_ff      <= NUM_POINTS_RST;
         cur_x_ff     <= START_X_RST;
         cur_y_ff     <= START_Y_RST;
         idx_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kn_ff        <= kn_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         idx_ff       <= idx_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_START_X:    start_x_ff <= csr_wdata;
               CSR_START_Y:    start_y_ff <= csr_wdata;
               CSR_STEP_SIZE:  step_ff    <= csr_wdata;
               CSR_NUM_POINTS: npts_ff    <= csr_wdata[CNT_BITS-1:0];
               default:        npts_ff    <= npts_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      ya_ff   <= ya_in;
      ny_ff   <= ny_in;
      avg_ff  <= avg_in;
      nsat_ff <= nsat_in;
      if (load) begin
         rsp_x_ff    <= cur_x_ff;
         rsp_y_ff    <= cur_y_ff;
         rsp_k_ff    <= k_ff;
         rsp_idx_ff  <= idx_ff;
         rsp_last_ff <= last;
         rsp_sat_ff  <= clip_ff;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_x_value      = rsp_x_ff;
   assign rsp_y_value      = rsp_y_ff;
   assign rsp_slope_one    = rsp_k_ff[0];
   assign rsp_slope_two    = rsp_k_ff[1];
   assign rsp_slope_three  = rsp_k_ff[2];
   assign rsp_slope_four   = rsp_k_ff[3];
   assign rsp_point_number = rsp_idx_ff;
   assign rsp_last_point   = rsp_last_ff;
   assign rsp_saturated    = rsp_sat_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside the final state");

   a_slope_done_waited: assert property (@(posedge clock) disable iff (reset)
      slp_rsp.done |-> (state_ff == ST_SWAIT))
      else $error("slope finished while sequencer was not waiting");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SLOPE) && req_stall)
      else $error("accepted beat did not start a step");

endmodule

// ===== bench/rk4_stepper_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rk4_stepper_checker
// Watches the step, result and register ports of the RK4 cosine stepper.
// A bit-exact software stepper with its own copy of the registers and of
// the current point predicts each result beat. Every result beat is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module rk4_stepper_checker import rk4_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_restart,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_x_value,
   input  logic signed [31:0] rsp_y_value,
   input  logic signed [21:0] rsp_slope_one,
   input  logic signed [21:0] rsp_slope_two,
   input  logic signed [21:0] rsp_slope_three,
   input  logic signed [21:0] rsp_slope_four,
   input  logic [15:0]        rsp_point_number,
   input  logic               rsp_last_point,
   input  logic               rsp_saturated,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 failures,
   output int                 points_pending
);

   typedef struct {
      word_type    x;
      word_type    y;
      slope_type   k1;
      slope_type   k2;
      slope_type   k3;
      slope_type   k4;
      logic [15:0] num;
      logic        last;
      logic        sat;
   } point_beat_t;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam longint ONE30 = 64'sd1 << 30;

   point_beat_t  expected_points[$];
   word_type     cfg_x0, cfg_y0, cfg_h;
   logic [15:0]  cfg_count;
   longint       cur_x, cur_y;
   logic [15:0]  cur_index;
   logic         cur_clipped;

   function automatic longint clamp_word(longint v, inout bit sat);
      if (v > WMAX) begin
         sat = 1;
         return WMAX;
      end
      if (v < WMIN) begin
         sat = 1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint add_sat(longint a, longint b, inout bit sat);
      return clamp_word(a + b, sat);
   endfunction

   function automatic longint mul_floor(longint a, longint b, int sh, inout bit sat);
      logic signed [127:0] pa, pb, pr;
      pa = a;
      pb = b;
      pr = (pa * pb) >>> sh;
      if (pr > 128'sd2147483647) begin
         sat = 1;
         return WMAX;
      end
      if (pr < -128'sd2147483648) begin
         sat = 1;
         return WMIN;
      end
      return longint'(pr);
   endfunction

   function automatic logic [31:0] turns_of(longint v);
      logic signed [127:0] pv, pc, pr;
      pv = v;
      pc = 128'sh28BE60DB9391054A;
      pr = pv * pc;
      return pr[83:52];
   endfunction

   function automatic longint taylor(longint unsigned a2, bit sine);
      longint t;
      longint unsigned p, d;
      int i;
      t = ONE30;
      for (i = 0; i < 6; i++) begin
         case (i)
            0: d = sine ? 156 : 132;
            1: d = sine ? 110 : 90;
            2: d = sine ? 72 : 56;
            3: d = sine ? 42 : 30;
            4: d = sine ? 20 : 12;
            default: d = sine ? 6 : 2;
         endcase
         p = a2 * longint'(t < 0 ? 0 : t);
         t = ONE30 - longint'((p >> 30) / d);
      end
      return t;
   endfunction

   function automatic longint cos_slope(longint x, longint y);
      logic [31:0] ph;
      longint unsigned a, a2, r;
      longint c, t, u;
      ph = turns_of(x) + turns_of(y);
      r = ph[29:0];
      a = (r * 64'd6746518852) >> 32;
      a2 = (a * a) >> 30;
      if (ph[31:30] == 2'd0 || ph[31:30] == 2'd2) begin
         c = taylor(a2, 0);
      end else begin
         t = taylor(a2, 1);
         c = longint'((a * longint'(t < 0 ? 0 : t)) >> 30);
      end
      if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) c = -c;
      if (c > ONE30) c = ONE30;
      if (c < -ONE30) c = -ONE30;
      u = (c + ONE30 + 512) >>> 10;
      return u - (64'sd1 << 20);
   endfunction

   function automatic longint floor_sixth(longint v);
      longint q;
      q = v / 6;
      if (v % 6 < 0) q--;
      return q;
   endfunction

   task automatic reload_point();
      cur_x = cfg_x0;
      cur_y = cfg_y0;
      cur_index = '0;
      cur_clipped = 0;
   endtask

   task automatic predict_step(bit restart);
      bit scratch, sat;
      longint x, y, h, xh, xf, k1, k2, k3, k4, avg, ym;
      point_beat_t e;
      scratch = 0;
      sat = 0;
      if (restart) reload_point();
      x = cur_x;
      y = cur_y;
      h = cfg_h;
      k1 = cos_slope(x, y);
      xh = add_sat(x, mul_floor(h, 1, 1, scratch), scratch);
      k2 = cos_slope(xh, add_sat(y, mul_floor(h, k1, FRAC_BITS + 1, scratch), scratch));
      k3 = cos_slope(xh, add_sat(y, mul_floor(h, k2, FRAC_BITS + 1, scratch), scratch));
      xf = add_sat(x, h, scratch);
      k4 = cos_slope(xf, add_sat(y, mul_floor(h, k3, FRAC_BITS, scratch), scratch));
      e.x = word_type'(x);
      e.y = word_type'(y);
      e.k1 = slope_type'(k1);
      e.k2 = slope_type'(k2);
      e.k3 = slope_type'(k3);
      e.k4 = slope_type'(k4);
      e.num = cur_index;
      e.last = (32'(cur_index) + 1 >= 32'(cfg_count));
      e.sat = cur_clipped;
      expected_points.push_back(e);
      if (e.last) begin
         reload_point();
      end else begin
         avg = floor_sixth(k1 + 2 * k2 + 2 * k3 + k4 + 3);
         cur_x = add_sat(x, h, sat);
         ym = mul_floor(h, avg, FRAC_BITS, sat);
         cur_y = add_sat(y, ym, sat);
         cur_clipped = sat;
         cur_index = cur_index + 16'd1;
      end
   endtask

   task automatic check_beat();
      point_beat_t e;
      if (expected_points.size() == 0) begin
         failures++;
         if (failures <= 10) $display("unexpected result beat x=%0d y=%0d",
            rsp_x_value, rsp_y_value);
         return;
      end
      e = expected_points.pop_front();
      if (rsp_x_value !== e.x || rsp_y_value !== e.y || rsp_slope_one !== e.k1 ||
          rsp_slope_two !== e.k2 || rsp_slope_three !== e.k3 ||
          rsp_slope_four !== e.k4 || rsp_point_number !== e.num ||
          rsp_last_point !== e.last || rsp_saturated !== e.sat) begin
         failures++;
         if (failures <= 10) begin
            $display("mismatch exp x=%0d y=%0d k=%0d %0d %0d %0d n=%0d last=%0b sat=%0b",
               e.x, e.y, e.k1, e.k2, e.k3, e.k4, e.num, e.last, e.sat);
            $display("         got x=%0d y=%0d k=%0d %0d %0d %0d n=%0d last=%0b sat=%0b",
               rsp_x_value, rsp_y_value, rsp_slope_one, rsp_slope_two,
               rsp_slope_three, rsp_slope_four, rsp_point_number,
               rsp_last_point, rsp_saturated);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         failures = 0;
         cfg_x0 <= START_X_RST;
         cfg_y0 <= START_Y_RST;
         cfg_h <= STEP_SIZE_RST;
         cfg_count <= NUM_POINTS_RST;
         cur_x = START_X_RST;
         cur_y = START_Y_RST;
         cur_index = '0;
         cur_clipped = 0;
         expected_points.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_beat();
         if (req_valid && !req_stall) predict_step(req_restart);
         if (csr_write_en) begin
            case (csr_index)
               CSR_START_X:    cfg_x0 <= csr_wdata;
               CSR_START_Y:    cfg_y0 <= csr_wdata;
               CSR_STEP_SIZE:  cfg_h <= csr_wdata;
               CSR_NUM_POINTS: cfg_count <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      points_pending <= expected_points.size();
   end

endmodule

// ===== bench/rk4_ode_stepper_cosine_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rk4_ode_stepper_cosine_core_test
// Stimulus for the RK4 cosine stepper: register settings from the extremes
// to random ones, directed runs, then random step beats with random idling
// on both channels and one long hold-off on the result side.
// ---------------------------------------------------------------------------
module rk4_ode_stepper_cosine_core_test;
   import rk4_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_restart = 0;
   logic rsp_stall = 0;
   logic csr_write_en = 0;
   logic [1:0] csr_index = CSR_START_X;
   logic [31:0] csr_wdata = '0;
   logic req_stall, rsp_valid, rsp_last_point, rsp_saturated;
   logic signed [31:0] rsp_x_value, rsp_y_value;
   logic signed [21:0] rsp_slope_one, rsp_slope_two, rsp_slope_three, rsp_slope_four;
   logic [15:0] rsp_point_number;
   int failures, points_pending;
   int cycles = 0;
   bit calm = 0;
   bit hold_off = 0;

   rk4_ode_stepper_cosine_core uut (.*);
   rk4_stepper_checker checker_i (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side stalls
   always @(posedge clock) begin
      int burst;
      if (reset) begin
         burst = 0;
      end else if (hold_off) begin
         rsp_stall <= 1;
      end else if (calm) begin
         rsp_stall <= 0;
      end else if (burst > 0) begin
         burst--;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         burst = $urandom_range(0, 14);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_step(bit restart);
      req_valid <= 1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] x0, logic [31:0] y0, logic [31:0] h,
                             logic [31:0] count);
      csr_write_en <= 1;
      csr_index <= CSR_START_X;
      csr_wdata <= x0;
      @(posedge clock);
      csr_index <= CSR_START_Y;
      csr_wdata <= y0;
      @(posedge clock);
      csr_index <= CSR_STEP_SIZE;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_NUM_POINTS;
      csr_wdata <= count;
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   initial begin
      int n, phase;
      logic [31:0] h;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults, then restart at once
      send_step(0);
      send_step(1);
      send_step(0);
      settle();
      // zero count: every beat is last
      write_regs(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h0);
      send_step(1);
      send_step(0);
      settle();
      // x and y run into the upper bound
      write_regs(32'h7FF00000, 32'h7FF00000, 32'h7FFFFFFF, 32'hFFFF);
      send_step(1);
      send_step(0);
      send_step(0);
      settle();
      write_regs(32'h80000000, 32'h80000000, 32'h80000001, 32'd3);
      repeat (4) send_step(0);
      send_step(1);
      settle();
      // a restarted run, then the count shortened below the current index
      write_regs(32'h0, 32'hFFF00000, 32'd104858, 32'd20);
      send_step(1);
      repeat (5) send_step(0);
      settle();
      write_regs(32'h0, 32'hFFF00000, 32'd0, 32'hFFFF0002);
      send_step(0);
      send_step(0);
      settle();

      // the result side holds off while beats keep coming
      write_regs($urandom, $urandom, 32'd50000, 32'd30);
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         repeat (12) send_step(0);
      join
      settle();

      for (phase = 0; phase < 16; phase++) begin
         case ($urandom_range(0, 3))
            0: h = $urandom;
            1: h = 32'($signed($urandom_range(0, 400000)) - 200000);
            2: h = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: h = $urandom_range(1000, 300000);
         endcase
         n = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 40);
         if (phase == 15) calm = 1;
         write_regs($urandom, $urandom, h, {16'($urandom_range(0, 65535)), 16'(n)});
         repeat (50) send_step($urandom_range(0, 9) == 0);
         settle();
      end

      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
